### design/pit3_pkg.sv
// ----------------------------------------------------------------------------
// pit3_pkg
// Shared types and codes for the three-channel interval timer.
// ----------------------------------------------------------------------------
package pit3_pkg;

    localparam int NUM_CH = 3;

    // Item kinds on the input channel.
    typedef enum logic [1:0] {
        ITEM_WRITE = 2'd0,
        ITEM_READ  = 2'd1,
        ITEM_TICK  = 2'd2,
        ITEM_NONE  = 2'd3
    } pit3_item_t;

    localparam logic [1:0] CTRL_PORT     = 2'd3;
    localparam logic [1:0] SEL_READBACK  = 2'd3;

    // Access kinds from the control word.
    localparam logic [1:0] ACC_LATCH = 2'd0;
    localparam logic [1:0] ACC_LSB   = 2'd1;
    localparam logic [1:0] ACC_MSB   = 2'd2;
    localparam logic [1:0] ACC_WORD  = 2'd3;

    // Read and write sequence codes.
    localparam logic [2:0] SEQ_MSB     = 3'd2;
    localparam logic [2:0] SEQ_WORD_LO = 3'd3;
    localparam logic [2:0] SEQ_WORD_HI = 3'd4;

    // Counter modes.
    localparam logic [2:0] MODE_ONE_SHOT = 3'd1;
    localparam logic [2:0] MODE_RATE     = 3'd2;
    localparam logic [2:0] MODE_SQUARE   = 3'd3;
    localparam logic [2:0] MODE_SW_STB   = 3'd4;
    localparam logic [2:0] MODE_HW_STB   = 3'd5;
    localparam logic [2:0] MODE_LAST     = 3'd5;
    localparam logic [2:0] MODE_FOLD     = 3'd4;

    localparam logic [16:0] FULL_COUNT = 17'h10000;

    // Operation for one channel, decoded from one input item.
    typedef struct packed {
        logic       tick;
        logic       wr_count;
        logic       rd;
        logic       prog;
        logic       latch_cnt;
        logic       latch_sts;
        logic [7:0] data;
    } pit3_cmd_t;

endpackage

### design/pit3_chan.sv
// ----------------------------------------------------------------------------
// pit3_chan
// State and update logic of one timer channel: tick, count load, control
// word programming, latches and byte reads.
// ----------------------------------------------------------------------------
module pit3_chan (
    input  logic                aclk,
    input  logic                aresetn,
    input  pit3_pkg::pit3_cmd_t cmd,
    output logic [7:0]          rd_byte,
    output logic                level
);

    logic [16:0] reload_reg, reload_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [15:0] phase_reg, phase_next;
    logic        ez_reg, ez_next;
    logic        reached_reg, reached_next;
    logic        eq_reg, eq_next;
    logic [2:0]  mode_reg, mode_next;
    logic [1:0]  acc_reg, acc_next;
    logic        bcd_reg, bcd_next;
    logic [2:0]  rseq_reg, rseq_next;
    logic [2:0]  wseq_reg, wseq_next;
    logic [7:0]  pend_lo_reg, pend_lo_next;
    logic [15:0] held_cnt_reg, held_cnt_next;
    logic [1:0]  held_ph_reg, held_ph_next;
    logic [7:0]  held_sts_reg, held_sts_next;
    logic        sts_pend_reg, sts_pend_next;

    logic [16:0] tick_p;
    logic        tick_hit;
    logic        load_en;
    logic [15:0] load_val;
    logic [15:0] cur_count;
    logic        cur_level;
    logic [2:0]  prog_mode;

    function automatic logic [15:0] count_of(input logic [2:0]  m,
                                             input logic [16:0] n,
                                             input logic [15:0] p,
                                             input logic [15:0] e);
        logic [16:0] twice;
        logic [16:0] diff;
        twice = {p, 1'b0};
        case (m)
            pit3_pkg::MODE_RATE: begin
                diff = n - {1'b0, p};
            end
            pit3_pkg::MODE_SQUARE: begin
                if (twice >= n) begin
                    twice = twice - n;
                end
                diff = n - twice;
            end
            default: begin
                diff = n - {1'b0, e};
            end
        endcase
        return diff[15:0];
    endfunction

    function automatic logic level_of(input logic [2:0]  m,
                                      input logic [16:0] n,
                                      input logic [15:0] p,
                                      input logic        ez,
                                      input logic        reached,
                                      input logic        eq);
        logic [16:0] half;
        logic        lv;
        half = (n + 17'd1) >> 1;
        case (m) inside
            pit3_pkg::MODE_ONE_SHOT:                       lv = !reached;
            pit3_pkg::MODE_RATE:                           lv = (p == 16'd0) && !ez;
            pit3_pkg::MODE_SQUARE:                         lv = {1'b0, p} < half;
            pit3_pkg::MODE_SW_STB, pit3_pkg::MODE_HW_STB:  lv = eq;
            default:                                       lv = reached;
        endcase
        return lv;
    endfunction

    assign cur_count = count_of(mode_reg, reload_reg, phase_reg, elapsed_reg);
    assign cur_level = level_of(mode_reg, reload_reg, phase_reg, ez_reg,
                                reached_reg, eq_reg);
    assign tick_p    = {1'b0, phase_reg} + 17'd1;
    assign tick_hit  = !reached_reg && (tick_p == reload_reg);
    assign prog_mode = (cmd.data[3:1] > pit3_pkg::MODE_LAST) ?
                       cmd.data[3:1] - pit3_pkg::MODE_FOLD : cmd.data[3:1];

    always_comb begin
        reload_next   = reload_reg;
        elapsed_next  = elapsed_reg;
        phase_next    = phase_reg;
        ez_next       = ez_reg;
        reached_next  = reached_reg;
        eq_next       = eq_reg;
        mode_next     = mode_reg;
        acc_next      = acc_reg;
        bcd_next      = bcd_reg;
        rseq_next     = rseq_reg;
        wseq_next     = wseq_reg;
        pend_lo_next  = pend_lo_reg;
        held_cnt_next = held_cnt_reg;
        held_ph_next  = held_ph_reg;
        held_sts_next = held_sts_reg;
        sts_pend_next = sts_pend_reg;
        load_en       = 1'b0;
        load_val      = {8'h00, cmd.data};
        rd_byte       = 8'h00;

        if (cmd.tick) begin
            elapsed_next = elapsed_reg + 16'd1;
            // The phase never exceeds the count, so reaching it wraps to zero.
            phase_next   = (tick_p >= reload_reg) ? 16'd0 : tick_p[15:0];
            ez_next      = 1'b0;
            eq_next      = tick_hit;
            if (tick_hit) begin
                reached_next = 1'b1;
            end
        end

        if (cmd.prog) begin
            acc_next  = cmd.data[5:4];
            rseq_next = {1'b0, cmd.data[5:4]};
            wseq_next = {1'b0, cmd.data[5:4]};
            mode_next = prog_mode;
            bcd_next  = cmd.data[0];
        end

        if (cmd.wr_count) begin
            case (wseq_reg)
                pit3_pkg::SEQ_MSB: begin
                    load_en  = 1'b1;
                    load_val = {cmd.data, 8'h00};
                end
                pit3_pkg::SEQ_WORD_LO: begin
                    pend_lo_next = cmd.data;
                    wseq_next    = pit3_pkg::SEQ_WORD_HI;
                end
                pit3_pkg::SEQ_WORD_HI: begin
                    load_en   = 1'b1;
                    load_val  = {cmd.data, pend_lo_reg};
                    wseq_next = pit3_pkg::SEQ_WORD_LO;
                end
                default: begin
                    load_en = 1'b1;
                end
            endcase
        end

        if (load_en) begin
            // A count of zero stands for the full 65536.
            reload_next  = (load_val == 16'd0) ? pit3_pkg::FULL_COUNT
                                               : {1'b0, load_val};
            elapsed_next = 16'd0;
            phase_next   = 16'd0;
            ez_next      = 1'b1;
            reached_next = 1'b0;
            eq_next      = 1'b0;
        end

        // A latch that is still held is not replaced.
        if (cmd.latch_cnt && (held_ph_reg == pit3_pkg::ACC_LATCH)) begin
            held_cnt_next = cur_count;
            held_ph_next  = acc_reg;
        end

        if (cmd.latch_sts && !sts_pend_reg) begin
            held_sts_next = {cur_level, 1'b0, acc_reg, mode_reg, bcd_reg};
            sts_pend_next = 1'b1;
        end

        if (cmd.rd) begin
            if (sts_pend_reg) begin
                rd_byte       = held_sts_reg;
                sts_pend_next = 1'b0;
            end else if (held_ph_reg != pit3_pkg::ACC_LATCH) begin
                case (held_ph_reg)
                    pit3_pkg::ACC_MSB: begin
                        rd_byte      = held_cnt_reg[15:8];
                        held_ph_next = pit3_pkg::ACC_LATCH;
                    end
                    pit3_pkg::ACC_WORD: begin
                        rd_byte      = held_cnt_reg[7:0];
                        held_ph_next = pit3_pkg::ACC_MSB;
                    end
                    default: begin
                        rd_byte      = held_cnt_reg[7:0];
                        held_ph_next = pit3_pkg::ACC_LATCH;
                    end
                endcase
            end else begin
                case (rseq_reg)
                    pit3_pkg::SEQ_MSB: begin
                        rd_byte = cur_count[15:8];
                    end
                    pit3_pkg::SEQ_WORD_LO: begin
                        rd_byte   = cur_count[7:0];
                        rseq_next = pit3_pkg::SEQ_WORD_HI;
                    end
                    pit3_pkg::SEQ_WORD_HI: begin
                        rd_byte   = cur_count[15:8];
                        rseq_next = pit3_pkg::SEQ_WORD_LO;
                    end
                    default: begin
                        rd_byte = cur_count[7:0];
                    end
                endcase
            end
        end
    end

    // Level as it stands once this item has taken effect.
    assign level = level_of(mode_next, reload_next, phase_next, ez_next,
                            reached_next, eq_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reload_reg   <= pit3_pkg::FULL_COUNT;
            elapsed_reg  <= 16'd0;
            phase_reg    <= 16'd0;
            ez_reg       <= 1'b1;
            reached_reg  <= 1'b0;
            eq_reg       <= 1'b0;
            mode_reg     <= 3'd0;
            acc_reg      <= pit3_pkg::ACC_LATCH;
            bcd_reg      <= 1'b0;
            rseq_reg     <= 3'd0;
            wseq_reg     <= 3'd0;
            pend_lo_reg  <= 8'h00;
            held_cnt_reg <= 16'd0;
            held_ph_reg  <= pit3_pkg::ACC_LATCH;
            held_sts_reg <= 8'h00;
            sts_pend_reg <= 1'b0;
        end else begin
            reload_reg   <= reload_next;
            elapsed_reg  <= elapsed_next;
            phase_reg    <= phase_next;
            ez_reg       <= ez_next;
            reached_reg  <= reached_next;
            eq_reg       <= eq_next;
            mode_reg     <= mode_next;
            acc_reg      <= acc_next;
            bcd_reg      <= bcd_next;
            rseq_reg     <= rseq_next;
            wseq_reg     <= wseq_next;
            pend_lo_reg  <= pend_lo_next;
            held_cnt_reg <= held_cnt_next;
            held_ph_reg  <= held_ph_next;
            held_sts_reg <= held_sts_next;
            sts_pend_reg <= sts_pend_next;
        end
    end

endmodule

### design/interval_timer_three_channel.sv
// A result is registered in the result register when its item leaves the input
// register. Items are taken at one per cycle while the output is not stalled;
// each item updates channel state between the input and result registers.
// Reset (aresetn low at a clock edge) loads every channel with a count of
// 65536, mode 0, and clears all latches and both pipeline valid flags.
// ----------------------------------------------------------------------------
// interval_timer_three_channel
// Three-channel 8254-style interval timer driven by byte writes, byte reads
// and ticks, with one result transfer per input transfer.
// ----------------------------------------------------------------------------
module interval_timer_three_channel (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [1:0] s_port,
    input  logic [7:0] s_write_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_byte,
    output logic       m_out_level0,
    output logic       m_out_level1,
    output logic       m_out_level2
);

    logic                in_valid_reg, in_valid_next;
    logic [1:0]          mode_reg;
    logic [1:0]          port_reg;
    logic [7:0]          data_reg;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          rd_out_reg;
    logic [2:0]          lvl_out_reg;
    logic                advance;
    logic                in_xfer;
    pit3_pkg::pit3_cmd_t cmd [pit3_pkg::NUM_CH];
    logic [7:0]          ch_rd [pit3_pkg::NUM_CH];
    logic [2:0]          ch_lvl;
    logic [7:0]          rd_any;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign in_xfer = s_valid && s_ready;

    always_comb begin
        for (int c = 0; c < pit3_pkg::NUM_CH; c++) begin
            cmd[c]      = '0;
            cmd[c].data = data_reg;
            if (advance) begin
                unique case (pit3_pkg::pit3_item_t'(mode_reg))
                    pit3_pkg::ITEM_WRITE: begin
                        if (port_reg == pit3_pkg::CTRL_PORT) begin
                            if (data_reg[7:6] == pit3_pkg::SEL_READBACK) begin
                                // Read-back: bits 3-1 pick channels 2-0.
                                if (data_reg[c + 1]) begin
                                    cmd[c].latch_cnt = !data_reg[5];
                                    cmd[c].latch_sts = !data_reg[4];
                                end
                            end else if (data_reg[7:6] == 2'(c)) begin
                                if (data_reg[5:4] == pit3_pkg::ACC_LATCH) begin
                                    cmd[c].latch_cnt = 1'b1;
                                end else begin
                                    cmd[c].prog = 1'b1;
                                end
                            end
                        end else if (port_reg == 2'(c)) begin
                            cmd[c].wr_count = 1'b1;
                        end
                    end
                    pit3_pkg::ITEM_READ: begin
                        cmd[c].rd = (port_reg == 2'(c));
                    end
                    pit3_pkg::ITEM_TICK: begin
                        cmd[c].tick = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    for (genvar g = 0; g < pit3_pkg::NUM_CH; g++) begin : g_chan
        pit3_chan u_chan (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (cmd[g]),
            .rd_byte (ch_rd[g]),
            .level   (ch_lvl[g])
        );
    end

    // Only the channel being read drives a nonzero byte.
    assign rd_any = ch_rd[0] | ch_rd[1] | ch_rd[2];

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_xfer) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            mode_reg <= s_mode;
            port_reg <= s_port;
            data_reg <= s_write_byte;
        end
        if (advance) begin
            rd_out_reg  <= rd_any;
            lvl_out_reg <= ch_lvl;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_read_byte  = rd_out_reg;
    assign m_out_level0 = lvl_out_reg[0];
    assign m_out_level1 = lvl_out_reg[1];
    assign m_out_level2 = lvl_out_reg[2];

    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while both stages are full and stalled");

    a_xfer_fills_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> in_valid_reg)
        else $error("input transfer did not fill the input register");

    a_advance_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("processed item produced no result");

    a_nonread_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (mode_reg != pit3_pkg::ITEM_READ)) |=> (m_read_byte == 8'h00))
        else $error("nonzero read byte for an item that is not a read");

endmodule
